/* rtl/i2cm_pkg.sv */
// Shared widths, codes and reset values for the I2C master byte engine.
package i2cm_pkg;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LIMIT_W = 8;
  localparam int unsigned PHASE_W = 4;
  localparam int unsigned BIT_W   = 4;

  localparam logic [LIMIT_W-1:0] ACK_LIMIT_RESET = 8'd12;
  localparam logic [BYTE_W-1:0]  MSB_MASK        = 8'h80;
  localparam logic [BIT_W-1:0]   BITS_PER_BYTE   = 4'd8;

  localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
  localparam logic [OP_W-1:0] OP_START     = 3'd1;
  localparam logic [OP_W-1:0] OP_STOP      = 3'd2;
  localparam logic [OP_W-1:0] OP_WRITE     = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_ACK  = 3'd4;
  localparam logic [OP_W-1:0] OP_READ_NACK = 3'd5;

endpackage

/* rtl/i2cm_if.sv */
// Channel interfaces of the I2C master byte engine.
interface i2cm_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [i2cm_pkg::OP_W-1:0]     op;
  logic [i2cm_pkg::BYTE_W-1:0]   wdata;
  logic                          sda_in;

  modport source (output valid, output op, output wdata, output sda_in, input ready);
  modport sink   (input valid, input op, input wdata, input sda_in, output ready);
endinterface

interface i2cm_res_if;
  logic                          valid;
  logic                          ready;
  logic                          scl;
  logic                          sda_out;
  logic                          busy_res;
  logic                          done_res;
  logic [i2cm_pkg::BYTE_W-1:0]   rdata;
  logic                          ack_ok;

  modport source (output valid, output scl, output sda_out, output busy_res,
                  output done_res, output rdata, output ack_ok, input ready);
  modport sink   (input valid, input scl, input sda_out, input busy_res,
                  input done_res, input rdata, input ack_ok, output ready);
endinterface

interface i2cm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [i2cm_pkg::LIMIT_W-1:0]  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/i2c_master_byte_engine.sv */
// Top level: I2C master half-bit phase engine with registered result.
//
//   channel  direction  payload                                        transaction
//   cmd      in         op, wdata, sda_in                              valid & ready
//   res      out        scl, sda_out, busy_res, done_res, rdata, ack_ok valid & ready
//   cfg      in         ack_wait_limit (data)                          valid & ready
//
// One transaction on cmd is one bus tick and gives one res result, valid in
// the next cycle; a tick is taken every cycle while the result register is empty
// or draining. The phase update is a single pass of combinational logic from
// the state registers to the result register. A stalled res holds its result
// and back-pressures cmd. Reset (rst, synchronous) idles the engine, releases
// both lines and loads ack_wait_limit with 12; no clearing pass is needed.
module i2c_master_byte_engine (
  input  logic              clk,
  input  logic              rst,
  i2cm_cmd_if.sink          cmd,
  i2cm_res_if.source        res,
  i2cm_cfg_if.sink          cfg
);

  localparam logic [i2cm_pkg::PHASE_W-1:0] PH_IDLE    = 4'd0;
  localparam logic [i2cm_pkg::PHASE_W-1:0] PH_ST_B    = 4'd1;
  localparam logic [i2cm_pkg::PHASE_W-1:0] PH_ST_C    = 4'd2;
  localparam logic [i2cm_pkg::PHASE_W-1:0] PH_SP_B    = 4'd3;
  localparam logic [i2cm_pkg::PHASE_W-1:0] PH_SP_C    = 4'd4;
  localparam logic [i2cm_pkg::PHASE_W-1:0] PH_W_LO    = 4'd5;
  localparam logic [i2cm_pkg::PHASE_W-1:0] PH_W_HI    = 4'd6;
  localparam logic [i2cm_pkg::PHASE_W-1:0] PH_WA_LO   = 4'd7;
  localparam logic [i2cm_pkg::PHASE_W-1:0] PH_WA_HI   = 4'd8;
  localparam logic [i2cm_pkg::PHASE_W-1:0] PH_WA_WAIT = 4'd9;
  localparam logic [i2cm_pkg::PHASE_W-1:0] PH_R_HI    = 4'd10;
  localparam logic [i2cm_pkg::PHASE_W-1:0] PH_R_LO    = 4'd11;
  localparam logic [i2cm_pkg::PHASE_W-1:0] PH_RA_HI   = 4'd12;
  localparam logic [i2cm_pkg::PHASE_W-1:0] PH_RA_END  = 4'd13;

  logic [i2cm_pkg::LIMIT_W-1:0] ack_wait_limit;
  logic [i2cm_pkg::PHASE_W-1:0] phase, phase_next;
  logic [i2cm_pkg::OP_W-1:0]    active_command, active_command_next;
  logic [i2cm_pkg::BIT_W-1:0]   bit_count, bit_count_next;
  logic [i2cm_pkg::BYTE_W-1:0]  shift_byte, shift_byte_next;
  logic [i2cm_pkg::LIMIT_W-1:0] ack_wait_count, ack_wait_count_next;
  logic                         line_scl, line_scl_next;
  logic                         line_sda, line_sda_next;
  logic                         last_ack, last_ack_next;
  logic [i2cm_pkg::BYTE_W-1:0]  read_reg, read_reg_next;
  logic                         done_next;

  logic                         res_valid;
  logic                         accept;

  assign cmd.ready = !res_valid || res.ready;
  assign accept    = cmd.valid && cmd.ready;
  assign cfg.ready = 1'b1;
  assign res.valid = res_valid;

  always_comb begin
    logic [i2cm_pkg::BIT_W-1:0] bit_inc;
    bit_inc             = bit_count + 4'd1;
    phase_next          = phase;
    active_command_next = active_command;
    bit_count_next      = bit_count;
    shift_byte_next     = shift_byte;
    ack_wait_count_next = ack_wait_count;
    line_scl_next       = line_scl;
    line_sda_next       = line_sda;
    last_ack_next       = last_ack;
    read_reg_next       = read_reg;
    done_next           = 1'b0;

    if (phase == PH_IDLE) begin
      unique case (cmd.op)
        i2cm_pkg::OP_START: begin
          line_scl_next       = 1'b1;
          line_sda_next       = 1'b1;
          phase_next          = PH_ST_B;
          active_command_next = cmd.op;
        end
        i2cm_pkg::OP_STOP: begin
          line_scl_next       = 1'b0;
          line_sda_next       = 1'b0;
          phase_next          = PH_SP_B;
          active_command_next = cmd.op;
        end
        i2cm_pkg::OP_WRITE: begin
          shift_byte_next     = cmd.wdata;
          bit_count_next      = '0;
          ack_wait_count_next = '0;
          line_scl_next       = 1'b0;
          line_sda_next       = |(cmd.wdata & i2cm_pkg::MSB_MASK);
          phase_next          = PH_W_HI;
          active_command_next = cmd.op;
        end
        i2cm_pkg::OP_READ_ACK, i2cm_pkg::OP_READ_NACK: begin
          shift_byte_next     = '0;
          bit_count_next      = '0;
          line_scl_next       = 1'b0;
          line_sda_next       = 1'b1;
          phase_next          = PH_R_HI;
          active_command_next = cmd.op;
        end
        default: begin
        end
      endcase
    end else begin
      unique case (phase)
        PH_ST_B: begin
          line_sda_next = 1'b0;
          phase_next    = PH_ST_C;
        end
        PH_ST_C: begin
          line_scl_next = 1'b0;
          done_next     = 1'b1;
        end
        PH_SP_B: begin
          line_scl_next = 1'b1;
          phase_next    = PH_SP_C;
        end
        PH_SP_C: begin
          line_sda_next = 1'b1;
          done_next     = 1'b1;
        end
        PH_W_LO: begin
          line_scl_next = 1'b0;
          line_sda_next = |(shift_byte & i2cm_pkg::MSB_MASK);
          phase_next    = PH_W_HI;
        end
        PH_W_HI: begin
          line_scl_next   = 1'b1;
          shift_byte_next = {shift_byte[i2cm_pkg::BYTE_W-2:0], 1'b0};
          bit_count_next  = bit_inc;
          phase_next      = (bit_inc >= i2cm_pkg::BITS_PER_BYTE) ? PH_WA_LO : PH_W_LO;
        end
        PH_WA_LO: begin
          line_scl_next = 1'b0;
          line_sda_next = 1'b1;
          phase_next    = PH_WA_HI;
        end
        PH_WA_HI: begin
          line_scl_next       = 1'b1;
          ack_wait_count_next = '0;
          phase_next          = PH_WA_WAIT;
        end
        PH_WA_WAIT: begin
          priority if (!cmd.sda_in) begin
            line_scl_next = 1'b0;
            last_ack_next = 1'b1;
            done_next     = 1'b1;
          end else if (ack_wait_count >= ack_wait_limit) begin
            line_scl_next = 1'b0;
            last_ack_next = 1'b0;
            done_next     = 1'b1;
          end else begin
            ack_wait_count_next = ack_wait_count + 8'd1;
          end
        end
        PH_R_HI: begin
          line_scl_next   = 1'b1;
          shift_byte_next = {shift_byte[i2cm_pkg::BYTE_W-2:0], cmd.sda_in};
          bit_count_next  = bit_inc;
          phase_next      = PH_R_LO;
        end
        PH_R_LO: begin
          line_scl_next = 1'b0;
          if (bit_count >= i2cm_pkg::BITS_PER_BYTE) begin
            line_sda_next = (active_command == i2cm_pkg::OP_READ_ACK) ? 1'b0 : 1'b1;
            phase_next    = PH_RA_HI;
          end else begin
            phase_next    = PH_R_HI;
          end
        end
        PH_RA_HI: begin
          line_scl_next = 1'b1;
          phase_next    = PH_RA_END;
        end
        PH_RA_END: begin
          line_scl_next = 1'b0;
          read_reg_next = shift_byte;
          done_next     = 1'b1;
        end
        default: begin
          phase_next          = PH_IDLE;
          active_command_next = i2cm_pkg::OP_TICK;
        end
      endcase
      if (done_next) begin
        phase_next          = PH_IDLE;
        active_command_next = i2cm_pkg::OP_TICK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_wait_limit <= i2cm_pkg::ACK_LIMIT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      ack_wait_limit <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      active_command <= i2cm_pkg::OP_TICK;
      bit_count      <= '0;
      shift_byte     <= '0;
      ack_wait_count <= '0;
      line_scl       <= 1'b1;
      line_sda       <= 1'b1;
      last_ack       <= 1'b0;
      read_reg       <= '0;
      res_valid      <= 1'b0;
    end else begin
      if (accept) begin
        phase          <= phase_next;
        active_command <= active_command_next;
        bit_count      <= bit_count_next;
        shift_byte     <= shift_byte_next;
        ack_wait_count <= ack_wait_count_next;
        line_scl       <= line_scl_next;
        line_sda       <= line_sda_next;
        last_ack       <= last_ack_next;
        read_reg       <= read_reg_next;
      end
      if (accept) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.scl      <= line_scl_next;
      res.sda_out  <= line_sda_next;
      res.busy_res <= (phase_next != PH_IDLE);
      res.done_res <= done_next;
      res.rdata    <= read_reg_next;
      res.ack_ok   <= last_ack_next;
    end
  end

endmodule

/* rtl/i2cm_checker.sv */
// Port-level checks for the I2C master byte engine and their binding.
module i2cm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          cmd_valid,
  input logic                          cmd_ready,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic                          res_scl,
  input logic                          res_sda_out,
  input logic                          res_busy_res,
  input logic                          res_done_res,
  input logic [i2cm_pkg::BYTE_W-1:0]   res_rdata,
  input logic                          res_ack_ok
);

  a_stall_blocks_cmd: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |-> !cmd_ready)
    else $error("cmd ready while result stalled");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> res_valid)
    else $error("accepted tick gave no result");

  a_result_from_accept: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(cmd_valid && cmd_ready))
    else $error("result without accepted tick");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_scl) && $stable(res_sda_out) &&
      $stable(res_busy_res) && $stable(res_done_res) && $stable(res_rdata) &&
      $stable(res_ack_ok))
    else $error("stalled result changed");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (cmd.valid),
  .cmd_ready    (cmd.ready),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .res_scl      (res.scl),
  .res_sda_out  (res.sda_out),
  .res_busy_res (res.busy_res),
  .res_done_res (res.done_res),
  .res_rdata    (res.rdata),
  .res_ack_ok   (res.ack_ok)
);
